/* sv/tfcm_pkg.sv */
`default_nettype none

package tfcm_pkg;

  // display_mode codes; the unused code behaves like MODE_NORMAL
  typedef enum logic [2:0] {
    MODE_NORMAL      = 3'd0,
    MODE_TEMPERATURE = 3'd1,
    MODE_HUMIDITY    = 3'd2,
    MODE_ELEVATION   = 3'd3,
    MODE_RADIATION   = 3'd4,
    MODE_RESOURCES   = 3'd5,
    MODE_BIOMES      = 3'd6
  } mode_t;

  localparam int unsigned MODE_W = 3;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [12:0]        humidity;
    logic [12:0]        elevation;
    logic [12:0]        radiation;
    logic [12:0]        resources;
    logic [7:0]         biome_id;
    logic [7:0]         base_red;
    logic [7:0]         base_green;
    logic [7:0]         base_blue;
    logic [7:0]         base_alpha;
    logic               tile_empty;
    logic signed [15:0] height;
  } cell_t;

  typedef struct packed {
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic [7:0] top_alpha;
    logic [7:0] left_red;
    logic [7:0] left_green;
    logic [7:0] left_blue;
    logic [7:0] right_red;
    logic [7:0] right_green;
    logic [7:0] right_blue;
    logic       draw_tile;
    logic       volumetric;
  } result_t;

endpackage

`default_nettype wire

/* sv/tfcm_map.sv */
`default_nettype none

module tfcm_map
  import tfcm_pkg::*;
(
  input  cell_t             tile,
  input  logic [MODE_W-1:0] mode,
  output result_t           res
);

  // floor(x/5), exact for x < 2730
  function automatic logic [8:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1639;
    return 9'(p >> 13);
  endfunction

  // floor(x/3), exact for x < 2048
  function automatic logic [9:0] div3(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd683;
    return 10'(p >> 11);
  endfunction

  // floor(x/25), exact for x < 4096
  function automatic logic [7:0] div25(input logic [11:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd5243;
    return 8'(p >> 17);
  endfunction

  function automatic logic [7:0] sat8(input logic [9:0] x);
    return (x > 10'd255) ? 8'd255 : x[7:0];
  endfunction

  function automatic logic [12:0] clamp_frac(input logic [12:0] x);
    return (x > 13'd4096) ? 13'd4096 : x;
  endfunction

  // biome colors by hue step (id mod 9), hue = 40 * step
  function automatic logic [23:0] biome_rgb(input logic [3:0] j);
    logic [23:0] c;
    case (j)
      4'd0:    c = {8'd229, 8'd45,  8'd45};
      4'd1:    c = {8'd229, 8'd168, 8'd45};
      4'd2:    c = {8'd168, 8'd229, 8'd45};
      4'd3:    c = {8'd45,  8'd229, 8'd45};
      4'd4:    c = {8'd45,  8'd229, 8'd168};
      4'd5:    c = {8'd45,  8'd168, 8'd229};
      4'd6:    c = {8'd45,  8'd45,  8'd229};
      4'd7:    c = {8'd168, 8'd45,  8'd229};
      4'd8:    c = {8'd229, 8'd45,  8'd168};
      default: c = {8'd229, 8'd45,  8'd45};
    endcase
    return c;
  endfunction

  // temperature ramp
  logic [16:0] t_ext;
  logic [16:0] t_mag;
  logic [9:0]  n_neg;
  logic [10:0] n_pos;
  logic [10:0] m_pos;
  logic [16:0] g_neg_sum;
  logic [9:0]  t_r, t_g, t_b;

  // humidity ramp
  logic [12:0] hum;
  logic [11:0] hd;
  logic [19:0] h_r_p, h_g_p, h_b_p;
  logic [9:0]  h_r, h_g, h_b;

  // elevation ramp
  logic [12:0] elev;
  logic [15:0] e10;
  logic [14:0] e25;
  logic [13:0] ed_mid, ed_hi;
  logic [21:0] em_r, em_g, em_b;
  logic [18:0] eh_r;
  logic [20:0] eh_g;
  logic [21:0] eh_b;
  logic [9:0]  e_r, e_g, e_b;

  // threshold levels
  logic [15:0] rad10, res10;
  logic [23:0] rad_rgb, res_rgb;

  // biomes
  logic [15:0] bq_p;
  logic [4:0]  bq;
  logic [7:0]  bj_full;
  logic [23:0] bio_rgb;

  logic [9:0]  c_r, c_g, c_b;
  logic [7:0]  top_r, top_g, top_b, top_a;
  logic        raised;

  always_comb begin
    t_ext = {tile.temperature[15], tile.temperature};
    t_mag = tile.temperature[15] ? (17'd0 - t_ext) : t_ext;
    n_neg = (t_mag > 17'd800) ? 10'd800 : t_mag[9:0];
    n_pos = (t_mag > 17'd1600) ? 11'd1600 : t_mag[10:0];
    m_pos = 11'd1600 - n_pos;
    g_neg_sum = 17'd80000 + 17'(n_neg) * 17'd55;
    if (tile.temperature[15]) begin
      t_r = 10'((10'd800 - n_neg) >> 3);
      t_g = 10'(div25(12'(g_neg_sum >> 5)));
      t_b = 10'd255;
    end else if (n_pos < 11'd800) begin
      t_r = 10'(div5(11'((16'(n_pos) * 16'd51) >> 5)));
      t_g = 10'd255;
      t_b = 10'((11'd800 - n_pos) >> 4);
    end else begin
      t_r = 10'd255;
      t_g = 10'(div5(11'((16'(m_pos) * 16'd51) >> 5)));
      t_b = 10'd0;
    end
  end

  always_comb begin
    hum = clamp_frac(tile.humidity);
    hd  = 12'(hum - 13'd2048);
    if (hum < 13'd2048) begin
      h_r_p = 20'd255 * 20'(13'd2048 - hum);
      h_g_p = 20'd522240 - 20'd100 * 20'(hum);
      h_b_p = 20'd102400 + 20'd100 * 20'(hum);
      h_r   = 10'(h_r_p >> 11);
    end else begin
      h_r_p = 20'd0;
      h_g_p = 20'd155 * 20'(13'd2048 - 13'(hd));
      h_b_p = 20'd307200 + 20'd105 * 20'(hd);
      h_r   = 10'd0;
    end
    h_g = 10'(h_g_p >> 11);
    h_b = 10'(h_b_p >> 11);
  end

  always_comb begin
    elev   = clamp_frac(tile.elevation);
    e10    = 16'(elev) * 16'd10;
    e25    = 15'(elev) * 15'd25;
    ed_mid = 14'(e10 - 16'd12288);
    ed_hi  = 14'(e10 - 16'd28672);
    em_r   = 22'd100 * 22'(ed_mid);
    em_g   = 22'd2293760 - 22'd40 * 22'(ed_mid);
    em_b   = 22'd983040 - 22'd40 * 22'(ed_mid);
    eh_r   = 19'd25 * 19'(ed_hi);
    eh_g   = 21'd155 * 21'(ed_hi);
    eh_b   = 22'd235 * 22'(ed_hi);
    if (e10 < 16'd12288) begin
      e_r = 10'd20 + 10'(e25 >> 9);
      e_g = 10'd80 + 10'(e25 >> 9);
      e_b = 10'd20 + div3(11'(e25 >> 8));
    end else if (e10 < 16'd28672) begin
      e_r = 10'd80 + 10'(em_r >> 14);
      e_g = 10'(em_g >> 14);
      e_b = 10'(em_b >> 14);
    end else begin
      e_r = 10'd180 + 10'(eh_r >> 12);
      e_g = 10'd100 + div3(11'(eh_g >> 12));
      e_b = 10'd20 + div3(11'(eh_b >> 12));
    end
  end

  always_comb begin
    rad10 = 16'(clamp_frac(tile.radiation)) * 16'd10;
    res10 = 16'(clamp_frac(tile.resources)) * 16'd10;
    if (rad10 < 16'd12288)      rad_rgb = {8'd50, 8'd200, 8'd50};
    else if (rad10 < 16'd28672) rad_rgb = {8'd230, 8'd230, 8'd0};
    else                        rad_rgb = {8'd255, 8'd50, 8'd50};
    if (res10 < 16'd12288)      res_rgb = {8'd150, 8'd150, 8'd150};
    else if (res10 < 16'd28672) res_rgb = {8'd50, 8'd50, 8'd200};
    else                        res_rgb = {8'd200, 8'd50, 8'd200};
  end

  always_comb begin
    bq_p    = 16'(tile.biome_id) * 16'd228;
    bq      = 5'(bq_p >> 11);
    bj_full = tile.biome_id - 8'(bq) * 8'd9;
    bio_rgb = biome_rgb(bj_full[3:0]);
  end

  always_comb begin
    top_a = 8'd255;
    unique case (mode)
      MODE_TEMPERATURE: begin
        c_r = t_r; c_g = t_g; c_b = t_b;
      end
      MODE_HUMIDITY: begin
        c_r = h_r; c_g = h_g; c_b = h_b;
      end
      MODE_ELEVATION: begin
        c_r = e_r; c_g = e_g; c_b = e_b;
      end
      MODE_RADIATION: begin
        c_r = 10'(rad_rgb[23:16]); c_g = 10'(rad_rgb[15:8]); c_b = 10'(rad_rgb[7:0]);
      end
      MODE_RESOURCES: begin
        c_r = 10'(res_rgb[23:16]); c_g = 10'(res_rgb[15:8]); c_b = 10'(res_rgb[7:0]);
      end
      MODE_BIOMES: begin
        c_r = 10'(bio_rgb[23:16]); c_g = 10'(bio_rgb[15:8]); c_b = 10'(bio_rgb[7:0]);
      end
      default: begin
        c_r   = 10'(tile.base_red);
        c_g   = 10'(tile.base_green);
        c_b   = 10'(tile.base_blue);
        top_a = tile.base_alpha;
      end
    endcase
    top_r = sat8(c_r);
    top_g = sat8(c_g);
    top_b = sat8(c_b);
  end

  always_comb begin
    raised = !tile.height[15] && (tile.height != 16'sd0);
    res = '0;
    if (!tile.tile_empty) begin
      res.top_red    = top_r;
      res.top_green  = top_g;
      res.top_blue   = top_b;
      res.top_alpha  = top_a;
      res.draw_tile  = 1'b1;
      res.volumetric = raised;
      if (raised) begin
        // 0.7 shade: floor(7c/10) = floor(floor(7c/2)/5)
        res.left_red    = 8'(div5(11'((11'(top_r) * 11'd7) >> 1)));
        res.left_green  = 8'(div5(11'((11'(top_g) * 11'd7) >> 1)));
        res.left_blue   = 8'(div5(11'((11'(top_b) * 11'd7) >> 1)));
        res.right_red   = top_r >> 1;
        res.right_green = top_g >> 1;
        res.right_blue  = top_b >> 1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/tile_false_color_mapper_top.sv */
// False-color mapper for map cells.
// Input stream (in_*): one word per cell with its measured properties; the
// empty flag rides on in_tuser. Output stream (out_*): one word per cell with
// the top face color and the left/right side shades; draw and volumetric
// flags ride on out_tuser. Every input word yields exactly one output word.
// Configuration: APB-style port, display_mode at byte address 0. Change it
// only while no word is in flight.
// Path: input register, mapping logic, result register; out_tvalid rises once
// the word sits in the result register. Throughput: one word per cycle while
// out_tready stays high; the whole mapping is a single pass of constant
// multiplies and shifts between the two registers.
// Reset (rst_n low, synchronous): both stages empty, display_mode = normal.
// Stall: when out_tready is low the result register holds; the input register
// takes one more word if empty, then in_tready drops until the result drains.
`default_nettype none

module tile_false_color_mapper_top
  import tfcm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  // in_tdata, from bit 0 up: temperature[15:0], humidity[28:16],
  // elevation[41:29], radiation[54:42], resources[67:55], biome_id[75:68],
  // base_red[83:76], base_green[91:84], base_blue[99:92],
  // base_alpha[107:100], height[123:108], zero fill[127:124]
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [127:0]  in_tdata,
  // in_tuser: tile_empty[0]
  input  wire logic [0:0]    in_tuser,
  // out_tdata, from bit 0 up: top_red, top_green, top_blue, top_alpha,
  // left_red, left_green, left_blue, right_red, right_green, right_blue
  // (8 bits each)
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [79:0]        out_tdata,
  // out_tuser: draw_tile[0], volumetric[1]
  output logic [1:0]         out_tuser,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic REG_DISPLAY_MODE = 1'b0;

  logic [MODE_W-1:0] mode_r;
  logic              in_valid_r;
  logic              in_valid_nxt;
  cell_t             cell_r;
  cell_t             cell_in;
  logic              out_valid_r;
  logic              out_valid_nxt;
  result_t           res_r;
  result_t           res_map;
  logic              out_free;
  logic              cfg_wr;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DISPLAY_MODE);
  assign prdata = (paddr[2] == REG_DISPLAY_MODE) ? {29'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else if (cfg_wr) begin
      mode_r <= pwdata[MODE_W-1:0];
    end
  end

  // unpack the input word
  assign cell_in.temperature = in_tdata[15:0];
  assign cell_in.humidity    = in_tdata[28:16];
  assign cell_in.elevation   = in_tdata[41:29];
  assign cell_in.radiation   = in_tdata[54:42];
  assign cell_in.resources   = in_tdata[67:55];
  assign cell_in.biome_id    = in_tdata[75:68];
  assign cell_in.base_red    = in_tdata[83:76];
  assign cell_in.base_green  = in_tdata[91:84];
  assign cell_in.base_blue   = in_tdata[99:92];
  assign cell_in.base_alpha  = in_tdata[107:100];
  assign cell_in.height      = in_tdata[123:108];
  assign cell_in.tile_empty  = in_tuser[0];

  // result slot can take a new word when empty or being drained
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_free;

  assign in_valid_nxt  = in_tready ? in_tvalid : in_valid_r;
  assign out_valid_nxt = out_free ? in_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture the cell; hold while the result side is stalled
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cell_r <= cell_in;
    end
  end

  tfcm_map u_map (
    .tile (cell_r),
    .mode (mode_r),
    .res  (res_map)
  );

  // advance the mapped color into the result register
  always_ff @(posedge clk) begin
    if (in_valid_r && out_free) begin
      res_r <= res_map;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.right_blue, res_r.right_green, res_r.right_red,
                       res_r.left_blue, res_r.left_green, res_r.left_red,
                       res_r.top_alpha, res_r.top_blue, res_r.top_green,
                       res_r.top_red};
  assign out_tuser  = {res_r.volumetric, res_r.draw_tile};

endmodule

`default_nettype wire

/* test/tb_tile_false_color_mapper_top.sv */
`default_nettype none

module tb_tile_false_color_mapper_top;
  import tfcm_pkg::*;

  // Register map and run bounds
  localparam logic [2:0]  MODE_ADDR   = 3'd0;
  localparam logic [2:0]  MODE_UNUSED = 3'd7;   // no meaning; acts like normal mode
  localparam int unsigned LOW_EDGE    = 12288;  // 10 * 0.3 in Q0.12
  localparam int unsigned HIGH_EDGE   = 28672;  // 10 * 0.7 in Q0.12
  localparam int unsigned FRAC_ONE    = 4096;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RAND_PHASES = 12;
  localparam int          PHASE_WORDS = 160;

  typedef enum int {READ_STEADY, READ_RANDOM, READ_PATTERN} read_style_e;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  wire  logic   in_tready;
  logic [127:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  wire  logic   out_tvalid;
  logic         out_tready = 1'b0;
  wire  logic [79:0] out_tdata;
  wire  logic [1:0]  out_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  wire  logic [31:0] prdata;
  wire  logic   pready;

  tile_false_color_mapper_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mode the block holds right now, mirrored on every register write
  logic [2:0]  mode_now = MODE_NORMAL;

  cell_t       cells_to_send [$];   // cells not yet offered on the input
  result_t     colors_due [$];      // colors owed, oldest first
  cell_t       in_cell;             // cell currently on in_tdata
  int          words_offered = 0;
  int          words_taken = 0;
  int          words_checked = 0;
  int          mismatches = 0;
  int          cycle_cnt = 0;

  // Sender burst state and receiver stall state
  int          burst_left = 8;
  int          gap_left = 0;
  read_style_e read_style = READ_STEADY;
  int          read_span = 0;
  logic [7:0]  read_mask = 8'h01;

  // Values that sit on ramp knees and threshold edges
  int temp_edges [14] = '{-32768, -801, -800, -799, -1, 0, 1, 799, 800, 801,
                          1599, 1600, 1601, 32767};
  int frac_edges [13] = '{0, 1, 1228, 1229, 2047, 2048, 2049, 2867, 2868,
                          4095, 4096, 4097, 8191};

  string field_name [12] = '{"top_red", "top_green", "top_blue", "top_alpha",
                             "left_red", "left_green", "left_blue", "right_red",
                             "right_green", "right_blue", "draw_tile", "volumetric"};

  // ---------------------------------------------------------------------------
  // Color prediction
  // ---------------------------------------------------------------------------

  // Clamp a Q0.12 fraction to 1.0
  function automatic int unsigned frac_of(logic [12:0] raw);
    return (raw > 13'd4096) ? FRAC_ONE : int'(raw);
  endfunction

  // Three-level band: below 0.3, below 0.7, else top band
  function automatic int unsigned band_of(int unsigned v);
    if (10 * v < LOW_EDGE) return 0;
    if (10 * v < HIGH_EDGE) return 1;
    return 2;
  endfunction

  function automatic result_t color_of_cell(cell_t c, logic [2:0] mode);
    result_t     r;
    int unsigned rgb [3];
    int          t;
    int unsigned n, e, d, hue, k, lo, hi, fall, rise;
    r = '0;
    if (c.tile_empty) return r;
    r.top_alpha = 8'hFF;
    case (mode)
      MODE_TEMPERATURE: begin
        t = $signed(c.temperature);
        if (t < 0) begin
          // cold side: shade toward blue over 50 degrees
          n = (t < -800) ? 800 : -t;
          rgb = '{100 * (800 - n) / 800, (100 * (800 - n) + 155 * n) / 800, 255};
        end else begin
          // warm side: green to yellow, then yellow to red over 100 degrees
          n = (t > 1600) ? 1600 : t;
          if (n < 800) rgb = '{255 * n / 800, 255, 50 * (800 - n) / 800};
          else rgb = '{255, 255 * (1600 - n) / 800, 0};
        end
      end
      MODE_HUMIDITY: begin
        n = frac_of(c.humidity);
        if (n < 2048) begin
          rgb = '{255 * (2048 - n) / 2048, (255 * 2048 - 100 * n) / 2048,
                  (50 * 2048 + 100 * n) / 2048};
        end else begin
          d = n - 2048;
          rgb = '{0, 155 * (2048 - d) / 2048, (150 * 2048 + 105 * d) / 2048};
        end
      end
      MODE_ELEVATION: begin
        n = frac_of(c.elevation);
        e = 10 * n;
        if (e < LOW_EDGE) begin
          rgb = '{(20 * 12288 + 600 * n) / 12288, (80 * 12288 + 600 * n) / 12288,
                  (20 * 12288 + 400 * n) / 12288};
        end else if (e < HIGH_EDGE) begin
          d = e - LOW_EDGE;
          rgb = '{(80 * 16384 + 100 * d) / 16384, (140 * 16384 - 40 * d) / 16384,
                  (60 * 16384 - 40 * d) / 16384};
        end else begin
          d = e - HIGH_EDGE;
          rgb = '{(180 * 12288 + 75 * d) / 12288, (100 * 12288 + 155 * d) / 12288,
                  (20 * 12288 + 235 * d) / 12288};
        end
      end
      MODE_RADIATION: begin
        case (band_of(frac_of(c.radiation)))
          0:       rgb = '{50, 200, 50};
          1:       rgb = '{230, 230, 0};
          default: rgb = '{255, 50, 50};
        endcase
      end
      MODE_RESOURCES: begin
        case (band_of(frac_of(c.resources)))
          0:       rgb = '{150, 150, 150};
          1:       rgb = '{50, 50, 200};
          default: rgb = '{200, 50, 200};
        endcase
      end
      MODE_BIOMES: begin
        // HSV with S = 0.8, V = 0.9; channel levels in units of 1/300
        hue  = (c.biome_id * 40) % 360;
        k    = hue % 60;
        hi   = 2295 * 300 / 3000;
        lo   = 2295 * 60 / 3000;
        fall = 2295 * (300 - 4 * k) / 3000;
        rise = 2295 * (60 + 4 * k) / 3000;
        case (hue / 60)
          0:       rgb = '{hi, rise, lo};
          1:       rgb = '{fall, hi, lo};
          2:       rgb = '{lo, hi, rise};
          3:       rgb = '{lo, fall, hi};
          4:       rgb = '{rise, lo, hi};
          default: rgb = '{hi, lo, fall};
        endcase
      end
      default: begin
        // normal and the unused code: pass the cell's own color through
        rgb = '{c.base_red, c.base_green, c.base_blue};
        r.top_alpha = c.base_alpha;
      end
    endcase
    for (int j = 0; j < 3; j++)
      if (rgb[j] > 255) rgb[j] = 255;
    r.top_red   = 8'(rgb[0]);
    r.top_green = 8'(rgb[1]);
    r.top_blue  = 8'(rgb[2]);
    r.draw_tile = 1'b1;
    // raised block: left face at 0.7, right face at 0.5 of the top
    if ($signed(c.height) > 0) begin
      r.left_red    = 8'(rgb[0] * 7 / 10);
      r.left_green  = 8'(rgb[1] * 7 / 10);
      r.left_blue   = 8'(rgb[2] * 7 / 10);
      r.right_red   = 8'(rgb[0] / 2);
      r.right_green = 8'(rgb[1] / 2);
      r.right_blue  = 8'(rgb[2] / 2);
      r.volumetric  = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Word packing
  // ---------------------------------------------------------------------------

  function automatic logic [127:0] cell_word(cell_t c);
    return {4'b0, c.height, c.base_alpha, c.base_blue, c.base_green, c.base_red,
            c.biome_id, c.resources, c.radiation, c.elevation, c.humidity,
            c.temperature};
  endfunction

  function automatic result_t word_colors(logic [79:0] d, logic [1:0] u);
    result_t r;
    r.top_red     = d[7:0];
    r.top_green   = d[15:8];
    r.top_blue    = d[23:16];
    r.top_alpha   = d[31:24];
    r.left_red    = d[39:32];
    r.left_green  = d[47:40];
    r.left_blue   = d[55:48];
    r.right_red   = d[63:56];
    r.right_green = d[71:64];
    r.right_blue  = d[79:72];
    r.draw_tile   = u[0];
    r.volumetric  = u[1];
    return r;
  endfunction

  // Field i of a result, in output order; the two flags come last
  function automatic logic [7:0] field_val(result_t r, int i);
    if (i < 10) return r[81 - 8 * i -: 8];
    return (i == 10) ? {7'b0, r.draw_tile} : {7'b0, r.volumetric};
  endfunction

  // ---------------------------------------------------------------------------
  // Random cells
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] random_temperature();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'(temp_edges[$urandom_range(13)]);
      default: return 16'(int'($urandom_range(2600)) - 900);
    endcase
  endfunction

  // Mostly in range, some knees, some past 1.0 to hit the clamp
  function automatic logic [12:0] random_frac();
    case ($urandom_range(5))
      0:       return 13'($urandom_range(8191));
      1:       return 13'(frac_edges[$urandom_range(12)]);
      default: return 13'($urandom_range(4096));
    endcase
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    c.temperature = random_temperature();
    c.humidity    = random_frac();
    c.elevation   = random_frac();
    c.radiation   = random_frac();
    c.resources   = random_frac();
    c.biome_id    = 8'($urandom_range(255));
    c.base_red    = 8'($urandom_range(255));
    c.base_green  = 8'($urandom_range(255));
    c.base_blue   = 8'($urandom_range(255));
    c.base_alpha  = 8'($urandom_range(255));
    c.tile_empty  = ($urandom_range(9) == 0);
    // lean on heights around zero so the flat/raised edge is hit often
    if ($urandom_range(3) == 0) c.height = 16'(int'($urandom_range(2)) - 1);
    else c.height = 16'($urandom);
    return c;
  endfunction

  // Queue a cell whose measured fields all carry one probe value
  task automatic push_probe(input int v, input logic empty,
                            input logic [15:0] ht, input logic [7:0] base);
    cell_t c;
    c.temperature = 16'(v);
    c.humidity    = 13'(v);
    c.elevation   = 13'(v);
    c.radiation   = 13'(v);
    c.resources   = 13'(v);
    c.biome_id    = 8'(v);
    c.base_red    = base;
    c.base_green  = base;
    c.base_blue   = base;
    c.base_alpha  = base;
    c.tile_empty  = empty;
    c.height      = ht;
    cells_to_send.push_back(c);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration and phase control
  // ---------------------------------------------------------------------------

  // Write display_mode, then read it back
  task automatic set_display_mode(input logic [2:0] m);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= 32'(m);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(m)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("display_mode readback: expected %0d, got %0d", m, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    mode_now = m;
    @(posedge clk);
  endtask

  // Hold until every queued cell is taken and every owed color has come back
  task automatic wait_drained();
    while (cells_to_send.size() != 0 || in_tvalid || words_checked != words_taken)
      @(posedge clk);
  endtask

  task automatic begin_phase(input logic [2:0] m);
    wait_drained();
    set_display_mode(m);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: bursts of words with random gaps, fed from cells_to_send
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_cells
    logic next_valid;
    next_valid = in_tvalid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_tvalid || words_taken == words_offered) begin
      // previous word gone (or none); offer the next one unless in a gap
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (cells_to_send.size() != 0) begin
        in_cell = cells_to_send.pop_front();
        in_tdata <= cell_word(in_cell);
        in_tuser <= in_cell.tile_empty;
        words_offered = words_offered + 1;
        next_valid = 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_tvalid <= next_valid;
  end

  // ---------------------------------------------------------------------------
  // Output pacing: steady, random or rotating-mask stalls, changed per span
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : pace_reader
    if (read_span == 0) begin
      read_style = read_style_e'($urandom_range(2));
      read_span  = $urandom_range(16, 96);
      read_mask  = 8'($urandom) | 8'h01;
    end
    read_span = read_span - 1;
    read_mask = {read_mask[6:0], read_mask[7]};
    case (read_style)
      READ_STEADY: out_tready <= 1'b1;
      READ_RANDOM: out_tready <= ($urandom_range(3) != 0);
      default:     out_tready <= read_mask[0];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each output word against the oldest owed color, then
  // record the color owed for any word taken at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_words
    result_t seen, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen = word_colors(out_tdata, out_tuser);
        if (colors_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output word with nothing owed: %h / %b", out_tdata, out_tuser);
        end else begin
          want = colors_due.pop_front();
          for (int i = 0; i < 12; i++) begin
            if (field_val(seen, i) !== field_val(want, i)) begin
              mismatches++;
              if (mismatches <= 10)
                $display("word %0d %s: expected %0d, got %0d", words_checked,
                         field_name[i], field_val(want, i), field_val(seen, i));
            end
          end
          words_checked <= words_checked + 1;
        end
      end
      if (in_tvalid && in_tready) begin
        colors_due.push_back(color_of_cell(in_cell, mode_now));
        words_taken <= words_taken + 1;
      end
    end
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed corners per mode, then random phases over all modes
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // normal mode: empty cell, flat, most negative and largest heights
    begin_phase(MODE_NORMAL);
    push_probe(0, 1'b1, 16'sd256, 8'd255);
    push_probe(0, 1'b0, 16'sd0, 8'd255);
    push_probe(0, 1'b0, 16'h8000, 8'd128);
    push_probe(0, 1'b0, 16'h7FFF, 8'd255);
    push_probe(0, 1'b0, 16'sd1, 8'd0);

    begin_phase(MODE_UNUSED);
    push_probe(0, 1'b0, 16'sd300, 8'd200);

    // temperature: full cold, knees at -50, 0, 50 and 100 degrees, full hot
    begin_phase(MODE_TEMPERATURE);
    push_probe(-32768, 1'b0, 16'sd256, 8'd0);
    push_probe(-801, 1'b0, 16'sd256, 8'd0);
    push_probe(0, 1'b0, 16'sd256, 8'd0);
    push_probe(799, 1'b0, 16'sd256, 8'd0);
    push_probe(800, 1'b0, 16'sd256, 8'd0);
    push_probe(1601, 1'b0, 16'sd256, 8'd0);
    push_probe(32767, 1'b0, 16'sd256, 8'd0);

    // humidity: either side of one half, and past 1.0
    begin_phase(MODE_HUMIDITY);
    push_probe(2047, 1'b0, 16'sd256, 8'd0);
    push_probe(2048, 1'b0, 16'sd256, 8'd0);
    push_probe(8191, 1'b0, 16'sd256, 8'd0);

    begin_phase(MODE_ELEVATION);
    push_probe(1229, 1'b0, 16'sd256, 8'd0);
    push_probe(2868, 1'b0, 16'sd256, 8'd0);
    push_probe(4096, 1'b0, 16'sd256, 8'd0);

    // thresholds: just below 0.3 and 0.7, and a clamped value
    begin_phase(MODE_RADIATION);
    push_probe(1228, 1'b0, 16'sd256, 8'd0);
    push_probe(2867, 1'b0, 16'sd256, 8'd0);
    push_probe(8191, 1'b0, 16'sd256, 8'd0);

    begin_phase(MODE_RESOURCES);
    push_probe(1229, 1'b0, 16'sd256, 8'd0);
    push_probe(2868, 1'b0, 16'sd256, 8'd0);
    push_probe(0, 1'b0, 16'sd256, 8'd0);

    // biomes: hue 0, mid-sector, last sector, wrap past 360
    begin_phase(MODE_BIOMES);
    push_probe(0, 1'b0, 16'sd256, 8'd0);
    push_probe(1, 1'b0, 16'sd256, 8'd0);
    push_probe(8, 1'b0, 16'sd256, 8'd0);
    push_probe(255, 1'b0, 16'sd256, 8'd0);

    // random phases: every code once in order, then random codes;
    // each phase boundary also drains the pipe completely
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      begin_phase((ph < 8) ? 3'(ph) : 3'($urandom_range(7)));
      repeat (PHASE_WORDS) cells_to_send.push_back(random_cell());
    end

    wait_drained();
    // let any stray word show up before judging
    repeat (8) @(posedge clk);
    if (mismatches == 0 && colors_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
